[sv/window_multiplicity_trigger_unit_assert.svh]
// assertion macros for the window multiplicity trigger
`ifndef WINDOW_MULTIPLICITY_TRIGGER_UNIT_ASSERT_SVH
`define WINDOW_MULTIPLICITY_TRIGGER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define WMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("window trigger check failed");

// next-cycle implication, checked out of reset
`define WMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("window trigger check failed");

`endif

[sv/wmt_pkg.sv]
// shared types and constants of the window multiplicity trigger
`timescale 1ns / 1ps

package wmt_pkg;

    localparam int THRESHOLD_W = 18;
    localparam int WINBINS_W   = 9;
    localparam int HOLDOFF_W   = 12;
    localparam int HIT_W       = 10;
    localparam int BIN_W       = 20;
    localparam int TOTAL_W     = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    localparam logic [BIN_W-1:0]   BIN_MAX = 20'hFFFFF;
    localparam logic [TOTAL_W-1:0] SUM_MAX = 18'h3FFFF;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 18'd25;
    localparam logic [WINBINS_W-1:0]   WINBINS_RST   = 9'd199;
    localparam logic [HOLDOFF_W-1:0]   HOLDOFF_RST   = 12'd950;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINBINS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd2;

    typedef struct packed {
        logic               trigger;
        logic [BIN_W-1:0]   bin;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

[sv/window_multiplicity_trigger_unit.sv]
// sliding-window multiplicity trigger, top level
// a result is registered when its bin is accepted, into the skid stage if the output is held
// throughput: one bin per clock while hit_stall is low; the drop-out entry is prefetched
// a window_bins write starts a rebuild sweep over min(filled, window) stored bins,
// during which hit_stall is high and cfg_ready is low
// reset: async active low, registers to defaults, window empty, ram contents left as is
`timescale 1ns / 1ps

`include "window_multiplicity_trigger_unit_assert.svh"

module window_multiplicity_trigger_unit
    import wmt_pkg::*;
#(
    parameter int WINDOW_MAX = 256,
    parameter int COUNT_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // bin channel
    input  logic                     hit_valid,
    output logic                     hit_stall,
    input  logic [HIT_W-1:0]         hit_count,
    input  logic                     event_start,
    // result channel
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic                     trigger,
    output logic [BIN_W-1:0]         trigger_bin,
    output logic [TOTAL_W-1:0]       window_total,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    // address, fill count, exact sum, compare and extension widths
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int SW = COUNT_BITS + FW;
    localparam int XW = ((SW > TOTAL_W) ? SW : TOTAL_W) + 1;
    localparam int EW = (FW > WINBINS_W) ? FW : WINBINS_W;
    localparam int HX = (COUNT_BITS > HIT_W) ? COUNT_BITS : HIT_W;

    // sequencer codes
    localparam logic ST_RUN = 1'b0;
    localparam logic ST_SUM = 1'b1;

    // configuration registers
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [WINBINS_W-1:0]   window_bins_reg;
    logic [HOLDOFF_W-1:0]   holdoff_bins_reg;

    // window state
    logic                   st_reg, st_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [FW-1:0]          filled_reg, filled_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic [HOLDOFF_W-1:0]   hold_reg, hold_next;
    logic [BIN_W-1:0]       bin_reg, bin_next;

    // rebuild sweep
    logic [FW-1:0]          k_reg, k_next;
    logic [AW-1:0]          raddr_reg, raddr_next;

    // write-to-read forwarding for a one-bin window
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [COUNT_BITS-1:0]  fwd_data_reg;

    // output register and skid stage
    logic                   out_valid_reg, skid_valid_reg;
    result_t                out_res_reg, skid_res_reg;

    // ram port
    logic                   wr_en;
    logic [AW-1:0]          rd_addr;
    logic [COUNT_BITS-1:0]  ram_q;

    // item datapath
    logic                   hit_fire, out_fire, cfg_fire;
    logic [COUNT_BITS-1:0]  count;
    logic [AW-1:0]          wp0;
    logic [FW-1:0]          filled0;
    logic [SW-1:0]          sum0;
    logic [HOLDOFF_W-1:0]   hold0;
    logic [BIN_W-1:0]       bin0;
    logic [COUNT_BITS-1:0]  drop_data, drop;
    logic [SW:0]            sum_grow;
    logic [SW-1:0]          sum_new;
    logic [TOTAL_W-1:0]     total_sat;
    logic                   fire;
    logic [EW-1:0]          wb_ext;
    logic [FW-1:0]          w_eff, n_fill;
    result_t                res_new;

    // entry that leaves the window when the write pointer stands at wp
    function automatic logic [AW-1:0] drop_addr(input logic [AW-1:0] wp,
                                                input logic [FW-1:0] w);
        logic [FW:0] a;
        logic [FW:0] r;
        a = (FW + 1)'(wp);
        if (a >= (FW + 1)'(w))
        begin
            r = a - (FW + 1)'(w);
        end
        else
        begin
            r = a + (FW + 1)'(WINDOW_MAX) - (FW + 1)'(w);
        end
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == AW'(WINDOW_MAX - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(WINDOW_MAX - 1) : a - 1'b1;
    endfunction

    // handshakes
    assign hit_stall = skid_valid_reg || (st_reg == ST_SUM);
    assign cfg_ready = (st_reg == ST_RUN);
    assign hit_fire  = hit_valid && !hit_stall;
    assign out_fire  = out_valid_reg && !result_stall;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign result_valid = out_valid_reg;
    assign trigger      = out_res_reg.trigger;
    assign trigger_bin  = out_res_reg.bin;
    assign window_total = out_res_reg.total;

    // effective window length: zero acts as one, clamp to the ram depth
    assign wb_ext = EW'(window_bins_reg);
    always_comb
    begin
        if (wb_ext == '0)
        begin
            w_eff = FW'(1);
        end
        else if (wb_ext > EW'(WINDOW_MAX))
        begin
            w_eff = FW'(WINDOW_MAX);
        end
        else
        begin
            w_eff = FW'(wb_ext);
        end
    end
    assign n_fill = (filled_reg < w_eff) ? filled_reg : w_eff;

    // per-bin update: event start clears first, then hold-off, trigger or window add
    assign count   = COUNT_BITS'(HX'(hit_count));
    assign wp0     = event_start ? '0 : wp_reg;
    assign filled0 = event_start ? '0 : filled_reg;
    assign sum0    = event_start ? '0 : sum_reg;
    assign hold0   = event_start ? '0 : hold_reg;
    assign bin0    = event_start ? '0 : bin_reg;

    assign drop_data = fwd_valid_reg ? fwd_data_reg : ram_q;
    assign drop      = (filled0 >= w_eff) ? drop_data : '0;
    assign sum_grow  = (SW + 1)'(sum0) + (SW + 1)'(count) - (SW + 1)'(drop);
    assign sum_new   = SW'(sum_grow);
    assign total_sat = (XW'(sum_new) > XW'(SUM_MAX)) ? SUM_MAX : TOTAL_W'(sum_new);
    assign fire      = (hold0 == '0) && (total_sat > threshold_reg);
    assign wr_en     = hit_fire && (hold0 == '0);

    always_comb
    begin
        res_new.trigger = fire;
        res_new.bin     = bin0;
        res_new.total   = (hold0 == '0) ? total_sat : '0;
    end

    // next state of the window and the sweep
    always_comb
    begin
        st_next     = st_reg;
        wp_next     = wp_reg;
        filled_next = filled_reg;
        sum_next    = sum_reg;
        hold_next   = hold_reg;
        bin_next    = bin_reg;
        k_next      = k_reg;
        raddr_next  = raddr_reg;
        rd_addr     = drop_addr(wp_reg, w_eff);

        unique case (st_reg)
            ST_RUN:
            begin
                if (hit_fire)
                begin
                    bin_next = (bin0 != BIN_MAX) ? bin0 + 1'b1 : bin0;
                    if (hold0 != '0)
                    begin
                        // bin ignored during hold-off
                        hold_next   = hold0 - 1'b1;
                        wp_next     = wp0;
                        filled_next = filled0;
                        sum_next    = sum0;
                    end
                    else if (fire)
                    begin
                        // trigger: empty the window and start hold-off
                        wp_next     = '0;
                        filled_next = '0;
                        sum_next    = '0;
                        hold_next   = (holdoff_bins_reg == '0) ? '0
                                                               : holdoff_bins_reg - 1'b1;
                    end
                    else
                    begin
                        wp_next     = addr_inc(wp0);
                        filled_next = (filled0 == FW'(WINDOW_MAX)) ? filled0
                                                                   : filled0 + 1'b1;
                        sum_next    = sum_new;
                        hold_next   = '0;
                    end
                end
                // prefetch the entry that the next bin pushes out
                rd_addr = drop_addr(wp_next, w_eff);
                if (cfg_fire && (cfg_index == REG_WINBINS))
                begin
                    // new window length: rebuild the sum from the stored bins
                    st_next    = ST_SUM;
                    k_next     = '0;
                    sum_next   = '0;
                    raddr_next = addr_dec(wp_next);
                end
            end
            ST_SUM:
            begin
                if (k_reg < n_fill)
                begin
                    rd_addr = raddr_reg;
                end
                if (k_reg != '0)
                begin
                    sum_next = sum_reg + SW'(ram_q);
                end
                raddr_next = addr_dec(raddr_reg);
                if (k_reg == n_fill)
                begin
                    st_next = ST_RUN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            default:
            begin
                st_next = ST_RUN;
            end
        endcase

        fwd_valid_next = wr_en && (rd_addr == wp0);
    end

    wmt_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_window_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wp0),
        .wdata (count),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            window_bins_reg  <= WINBINS_RST;
            holdoff_bins_reg <= HOLDOFF_RST;
            st_reg           <= ST_RUN;
            wp_reg           <= '0;
            filled_reg       <= '0;
            sum_reg          <= '0;
            hold_reg         <= '0;
            bin_reg          <= '0;
            k_reg            <= '0;
            raddr_reg        <= '0;
            fwd_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            wp_reg        <= wp_next;
            filled_reg    <= filled_next;
            sum_reg       <= sum_next;
            hold_reg      <= hold_next;
            bin_reg       <= bin_next;
            k_reg         <= k_next;
            raddr_reg     <= raddr_next;
            fwd_valid_reg <= fwd_valid_next;

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_THRESHOLD: threshold_reg    <= cfg_data[THRESHOLD_W-1:0];
                    REG_WINBINS:   window_bins_reg  <= cfg_data[WINBINS_W-1:0];
                    REG_HOLDOFF:   holdoff_bins_reg <= cfg_data[HOLDOFF_W-1:0];
                    default:       ;
                endcase
            end

            // output beat and skid occupancy
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (hit_fire)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payloads and forwarded data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg <= count;
        end
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (hit_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_res_reg <= res_new;
            end
            else
            begin
                out_res_reg <= res_new;
            end
        end
    end

    // checks
    `WMT_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `WMT_ASSERT_NOW(a_fill_bounded, clk, rst_n, 1'b1, filled_reg <= FW'(WINDOW_MAX))
    `WMT_ASSERT_NOW(a_holdoff_empty, clk, rst_n, hold_reg != '0,
                    (filled_reg == '0) && (sum_reg == '0))
    `WMT_ASSERT_NEXT(a_rebuild_stalls, clk, rst_n,
                     cfg_fire && (cfg_index == REG_WINBINS), hit_stall && !cfg_ready)

endmodule

[sv/wmt_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module wmt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
